[rtl/core/bfa_pkg.sv]
`default_nettype none
package bfa_pkg;

    localparam int ARENA_BYTES_DEF  = 32768;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MAX_BLOCKS_DEF   = 64;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // one row of the block table
    typedef struct packed {
        logic [14:0] off;
        logic [15:0] size;
        logic        free;
    } t_entry;

endpackage
`default_nettype wire

[rtl/core/bfa_if.sv]
`default_nettype none
interface bfa_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] req_size;
    logic [14:0] block_addr;

    modport source(output valid, req_type, req_size, block_addr, input ready);
    modport sink(input valid, req_type, req_size, block_addr, output ready);
endinterface

interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [14:0] payload_addr;

    modport source(output valid, status, payload_addr, input ready);
    modport sink(input valid, status, payload_addr, output ready);
endinterface
`default_nettype wire

[rtl/core/bfa_table.sv]
`default_nettype none
module bfa_table #(
    parameter int DEPTH = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [IW-1:0]   i_waddr,
    input  wire bfa_pkg::t_entry i_wdata,
    input  wire logic [IW-1:0]   i_raddr,
    output bfa_pkg::t_entry      o_rdata
);

    bfa_pkg::t_entry mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/best_fit_block_allocator.sv]
// Best-fit allocator over a byte arena: an address-ordered block table (offset,
// payload size, free mark) held in a single-port-read/single-port-write memory,
// plus a top pointer for never-used space. Requests arrive on i_req and each
// gives exactly one transaction on o_rsp. The block takes one request at a time;
// a sequencer walks the table one entry per cycle through the registered read
// port. An allocate that finds no exact fit scans every live entry, then decides
// between the best free block, a carve from the top region and no space, and
// then loads the response register; an exact fit leaves the scan early. A free
// scans to the match, reads the successor, merges, shifts the table tail down
// one entry per cycle to close holes, then writes back or reclaims the tail
// and loads the response. A free of an unknown address answers after scanning
// every live entry. The block is ready again as soon as the response register
// is loaded; a response that is not taken downstream stalls the sequencer in
// its respond state.
// The live count, the number of live blocks, is at most MAX_BLOCKS. No clearing pass is
// needed after reset: only rows below the live count are ever read.
`default_nettype none
module best_fit_block_allocator #(
    parameter int ARENA_BYTES  = bfa_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [16:0]   ARENA17 = 17'(ARENA_BYTES);
    localparam logic [16:0]   HDR17   = 17'(HEADER_BYTES);
    localparam logic [15:0]   HDR16   = 16'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXC    = CW'(MAX_BLOCKS);

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_DECIDE = 8'b0000_0100,
        S_NEXT   = 8'b0000_1000,
        S_MERGE  = 8'b0001_0000,
        S_SHIFT  = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic        r_type, n_type;
    logic [15:0] r_req, n_req;
    logic [14:0] r_addr, n_addr;

    // arena bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic [15:0]   r_top, n_top;

    // table walk
    logic [CW-1:0] r_ptr, n_ptr;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;

    // best fit tracking
    logic            r_have, n_have;
    logic [IW-1:0]   r_best_idx, n_best_idx;
    bfa_pkg::t_entry r_best, n_best;

    // free and merge
    bfa_pkg::t_entry r_cur, n_cur;
    bfa_pkg::t_entry r_prev, n_prev;
    logic            r_prev_ok, n_prev_ok;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_nfree, n_nfree;
    logic [15:0]     r_sum, n_sum;
    logic [1:0]      r_k, n_k;
    logic [IW-1:0]   r_fidx, n_fidx;
    bfa_pkg::t_entry r_fin, n_fin;

    // result
    logic [1:0]  r_st, n_st;
    logic [14:0] r_pa, n_pa;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_st, n_out_st;
    logic [14:0] r_out_pa, n_out_pa;

    // memory port
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    bfa_pkg::t_entry mem_wdata;
    logic [IW-1:0]   mem_raddr;
    bfa_pkg::t_entry q;

    bfa_table #(
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (q)
    );

    // shared datapath pieces
    logic          issue_ok;
    logic [15:0]   q_pay;
    logic [16:0]   room;
    logic          carve;
    logic          pfree;
    logic          nfree;
    logic [CW-1:0] newc;
    logic [15:0]   top_pay;
    logic [15:0]   best_pay;

    assign issue_ok = (r_ptr < r_count);
    assign q_pay    = {1'b0, q.off} + HDR16;
    assign room     = ({1'b0, r_top} <= ARENA17) ? (ARENA17 - {1'b0, r_top}) : 17'd0;
    assign carve    = (!r_have || ({1'b0, r_best.size} > room))
                      && (({1'b0, r_req} + HDR17) <= room) && (r_count < MAXC);
    assign pfree    = r_prev_ok && r_prev.free;
    assign nfree    = r_pend && q.free;
    assign newc     = r_count - CW'(r_k);
    assign top_pay  = {1'b0, r_top[14:0]} + HDR16;
    assign best_pay = {1'b0, r_best.off} + HDR16;

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_st;
    assign o_rsp.payload_addr = r_out_pa;

    always_comb begin
        n_state = r_state;
        n_type = r_type;
        n_req = r_req;
        n_addr = r_addr;
        n_count = r_count;
        n_top = r_top;
        n_ptr = r_ptr;
        n_pend = r_pend;
        n_pidx = r_pidx;
        n_have = r_have;
        n_best_idx = r_best_idx;
        n_best = r_best;
        n_cur = r_cur;
        n_prev = r_prev;
        n_prev_ok = r_prev_ok;
        n_idx = r_idx;
        n_nfree = r_nfree;
        n_sum = r_sum;
        n_k = r_k;
        n_fidx = r_fidx;
        n_fin = r_fin;
        n_st = r_st;
        n_pa = r_pa;
        n_out_valid = r_out_valid;
        n_out_st = r_out_st;
        n_out_pa = r_out_pa;
        mem_we = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = q;
        mem_raddr = r_ptr[IW-1:0];

        // response taken downstream
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_type = i_req.req_type;
                    n_req = i_req.req_size;
                    n_addr = i_req.block_addr;
                    n_ptr = '0;
                    n_pend = 1'b0;
                    n_have = 1'b0;
                    n_prev_ok = 1'b0;
                    if (i_req.req_type == bfa_pkg::REQ_ALLOC
                        && (i_req.req_size == 16'd0 || {1'b0, i_req.req_size} > ARENA17)) begin
                        n_st = bfa_pkg::ST_BAD;
                        n_pa = '0;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // read one entry ahead, evaluate the one that just came back
                if (issue_ok) begin
                    n_ptr = r_ptr + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_ptr[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (r_type == bfa_pkg::REQ_ALLOC) begin
                        if (q.free && q.size == r_req) begin
                            mem_we = 1'b1;
                            mem_waddr = r_pidx;
                            mem_wdata = '{off: q.off, size: q.size, free: 1'b0};
                            n_st = bfa_pkg::ST_OK;
                            n_pa = q_pay[14:0];
                            n_state = S_RESP;
                        end else if (q.free && q.size > r_req
                                     && (!r_have || q.size < r_best.size)) begin
                            n_have = 1'b1;
                            n_best = q;
                            n_best_idx = r_pidx;
                        end
                    end else begin
                        if (q_pay == {1'b0, r_addr}) begin
                            if (q.free) begin
                                n_st = bfa_pkg::ST_BAD;
                                n_pa = '0;
                                n_state = S_RESP;
                            end else begin
                                n_cur = '{off: q.off, size: q.size, free: 1'b1};
                                n_idx = r_pidx;
                                n_state = S_NEXT;
                            end
                        end else begin
                            n_prev = q;
                            n_prev_ok = 1'b1;
                        end
                    end
                end else if (!issue_ok) begin
                    if (r_type == bfa_pkg::REQ_ALLOC) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_st = bfa_pkg::ST_BAD;
                        n_pa = '0;
                        n_state = S_RESP;
                    end
                end
            end
            S_DECIDE: begin
                if (carve) begin
                    mem_we = 1'b1;
                    mem_waddr = r_count[IW-1:0];
                    mem_wdata = '{off: r_top[14:0], size: r_req, free: 1'b0};
                    n_count = r_count + 1'b1;
                    n_top = 16'({1'b0, r_top} + {1'b0, r_req} + HDR17);
                    n_st = bfa_pkg::ST_OK;
                    n_pa = top_pay[14:0];
                end else if (r_have) begin
                    mem_we = 1'b1;
                    mem_waddr = r_best_idx;
                    mem_wdata = '{off: r_best.off, size: r_best.size, free: 1'b0};
                    n_st = bfa_pkg::ST_OK;
                    n_pa = best_pay[14:0];
                end else begin
                    n_st = bfa_pkg::ST_NOSPACE;
                    n_pa = '0;
                end
                n_state = S_RESP;
            end
            S_NEXT: begin
                // successor row arrives now if it exists
                n_nfree = nfree;
                n_sum = r_cur.size + (nfree ? (q.size + HDR16) : 16'd0);
                n_pend = 1'b0;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (pfree) begin
                    n_fin = '{off: r_prev.off, size: r_prev.size + r_sum + HDR16, free: 1'b1};
                    n_fidx = r_idx - 1'b1;
                end else begin
                    n_fin = '{off: r_cur.off, size: r_sum, free: 1'b1};
                    n_fidx = r_idx;
                end
                n_k = {1'b0, pfree} + {1'b0, r_nfree};
                n_ptr = CW'(r_idx) + 1'b1 + CW'(r_nfree);
                n_pend = 1'b0;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                // close the hole: row j+k moves down to row j
                if (issue_ok) begin
                    n_ptr = r_ptr + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_ptr[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we = 1'b1;
                    mem_waddr = r_pidx - IW'(r_k);
                    mem_wdata = q;
                end else if (!issue_ok) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // a free block at the table end goes back to the top region
                if (CW'(r_fidx) + 1'b1 == newc) begin
                    n_count = newc - 1'b1;
                    n_top = {1'b0, r_fin.off};
                end else begin
                    mem_we = 1'b1;
                    mem_waddr = r_fidx;
                    mem_wdata = r_fin;
                    n_count = newc;
                end
                n_st = bfa_pkg::ST_OK;
                n_pa = '0;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_st = r_st;
                    n_out_pa = r_pa;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top <= '0;
            r_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top <= n_top;
            r_pend <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_type <= n_type;
        r_req <= n_req;
        r_addr <= n_addr;
        r_ptr <= n_ptr;
        r_pidx <= n_pidx;
        r_have <= n_have;
        r_best_idx <= n_best_idx;
        r_best <= n_best;
        r_cur <= n_cur;
        r_prev <= n_prev;
        r_prev_ok <= n_prev_ok;
        r_idx <= n_idx;
        r_nfree <= n_nfree;
        r_sum <= n_sum;
        r_k <= n_k;
        r_fidx <= n_fidx;
        r_fin <= n_fin;
        r_st <= n_st;
        r_pa <= n_pa;
        r_out_st <= n_out_st;
        r_out_pa <= n_out_pa;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("block count above table depth");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_top} <= ARENA17) else $error("top pointer beyond arena");

    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != bfa_pkg::ST_OK) |-> o_rsp.payload_addr == 15'd0)
        else $error("failed transaction carries an address");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state != S_IDLE)
        else $error("request accepted but sequencer idle");
`endif

endmodule
`default_nettype wire
